@@ rtl/door_debounce_countdown_top_defines.svh @@
// ---------------------------------------------------------------------------
// Door debounce countdown: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef DOOR_DEBOUNCE_COUNTDOWN_TOP_DEFINES_SVH
`define DOOR_DEBOUNCE_COUNTDOWN_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dbc_pkg.sv @@
// ---------------------------------------------------------------------------
// dbc_pkg
// Types, codes and constants of the door debounce countdown block.
// ---------------------------------------------------------------------------
package dbc_pkg;

  localparam int unsigned DIST_W   = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned TICK_W   = 10;
  localparam int unsigned DUR_W    = 8;
  localparam int unsigned TIME_W   = 18;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] MS_PER_SECOND = TIME_W'(1000);

  // item kinds
  localparam logic [1:0] KIND_READING = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_SWITCH  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DISTANCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READINGS_NEEDED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS         = 2'd2;

  // configuration register reset values
  localparam logic [DIST_W-1:0]  OPEN_DISTANCE_RST   = 16'd300;
  localparam logic [COUNT_W-1:0] READINGS_NEEDED_RST = 8'd3;
  localparam logic [TICK_W-1:0]  TICK_MS_RST         = 10'd100;

  typedef struct packed {
    logic [DIST_W-1:0]  open_distance;
    logic [COUNT_W-1:0] readings_needed;
    logic [TICK_W-1:0]  tick_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DIST_W-1:0] distance;
    logic [DUR_W-1:0]  duration_s;
    logic              override_switch;
    logic              prompt_switch;
  } item_t;

  typedef struct packed {
    logic              lab_open;
    logic              door_open;
    logic              counting;
    logic [TIME_W-1:0] remaining_ms;
    logic              led_green;
    logic              led_red;
    logic              led_white;
    logic              led_yellow;
    logic              lab_changed;
    logic              special_prompt;
  } result_t;

endpackage

@@ rtl/dbc_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// dbc_cfg_regs
// Configuration register file: threshold, debounce run length, tick step.
// ---------------------------------------------------------------------------
module dbc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbc_pkg::DIST_W-1:0]     cfg_data,
  output dbc_pkg::cfg_t                  cfg
);
  import dbc_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_distance   <= OPEN_DISTANCE_RST;
      cfg_r.readings_needed <= READINGS_NEEDED_RST;
      cfg_r.tick_ms         <= TICK_MS_RST;
    end else if (wr_en) begin
      unique case (cfg_index)
        CFG_OPEN_DISTANCE:   cfg_r.open_distance   <= cfg_data;
        CFG_READINGS_NEEDED: cfg_r.readings_needed <= cfg_data[COUNT_W-1:0];
        CFG_TICK_MS:         cfg_r.tick_ms         <= cfg_data[TICK_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

@@ rtl/dbc_core.sv @@
// ---------------------------------------------------------------------------
// dbc_core
// Debounce and countdown state with its single-pass next-state logic.
// ---------------------------------------------------------------------------
module dbc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  dbc_pkg::cfg_t    cfg,
  input  logic             fire,
  input  dbc_pkg::item_t   item,
  output dbc_pkg::result_t result
);
  import dbc_pkg::*;

  logic               raw_open_r,  raw_open_nxt;
  logic [COUNT_W-1:0] agree_r,     agree_nxt;
  logic               door_r,      door_nxt;
  logic               cand_r,      cand_nxt;
  logic               lab_r,       lab_nxt;
  logic               run_r,       run_nxt;
  logic [TIME_W-1:0]  time_r,      time_nxt;
  logic               blink_r,     blink_nxt;
  logic [DUR_W-1:0]   dur_r,       dur_nxt;
  logic               ovr_r,       ovr_nxt;
  logic               prompt_r,    prompt_nxt;
  logic               changed;

  logic               seen;
  logic [TIME_W-1:0]  full_time;
  logic [TIME_W-1:0]  tick_ext;

  // 255 s * 1000 still fits in the time width
  assign full_time = TIME_W'(dur_r) * MS_PER_SECOND;
  assign tick_ext  = TIME_W'(cfg.tick_ms);
  assign seen      = (item.distance != '0) && (item.distance <= cfg.open_distance);

  always_comb begin
    raw_open_nxt = raw_open_r;
    agree_nxt    = agree_r;
    door_nxt     = door_r;
    cand_nxt     = cand_r;
    lab_nxt      = lab_r;
    run_nxt      = run_r;
    time_nxt     = time_r;
    blink_nxt    = blink_r;
    dur_nxt      = dur_r;
    ovr_nxt      = ovr_r;
    prompt_nxt   = prompt_r;
    changed      = 1'b0;

    case (item.kind)
      KIND_READING: begin
        if (seen == raw_open_r) begin
          if (agree_r < cfg.readings_needed) begin
            agree_nxt = agree_r + COUNT_W'(1);
          end
        end else begin
          raw_open_nxt = seen;
          agree_nxt    = COUNT_W'(1);
        end
        if (agree_nxt >= cfg.readings_needed) begin
          door_nxt = raw_open_nxt;
        end
        // start a countdown toward the new door state
        if ((door_nxt != lab_r) && !run_r && !ovr_r) begin
          cand_nxt = door_nxt;
          time_nxt = full_time;
          run_nxt  = 1'b1;
        end
        // cancel on reversion or while override is on
        if (run_nxt && ((cand_nxt != door_nxt) || ovr_r)) begin
          time_nxt = full_time;
          run_nxt  = 1'b0;
        end
      end
      KIND_TICK: begin
        if (run_r) begin
          blink_nxt = ~blink_r;
          if (time_r <= tick_ext) begin
            time_nxt = '0;
            run_nxt  = 1'b0;
            lab_nxt  = cand_r;
            changed  = 1'b1;
          end else begin
            time_nxt = time_r - tick_ext;
          end
        end
      end
      KIND_SWITCH: begin
        if (!run_r) begin
          dur_nxt = item.duration_s;
        end
        ovr_nxt    = item.override_switch;
        prompt_nxt = item.prompt_switch;
      end
      default: ;  // unused kind: state holds
    endcase
  end

  always_comb begin
    result.lab_open       = lab_nxt;
    result.door_open      = door_nxt;
    result.counting       = run_nxt;
    result.remaining_ms   = time_nxt;
    result.led_green      = lab_nxt;
    result.led_red        = ~lab_nxt;
    result.led_white      = run_nxt & ~blink_nxt;
    result.led_yellow     = ovr_nxt;
    result.lab_changed    = changed;
    result.special_prompt = prompt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_open_r <= 1'b0;
      agree_r    <= '0;
      door_r     <= 1'b0;
      cand_r     <= 1'b0;
      lab_r      <= 1'b0;
      run_r      <= 1'b0;
      time_r     <= '0;
      blink_r    <= 1'b0;
      dur_r      <= '0;
      ovr_r      <= 1'b0;
      prompt_r   <= 1'b0;
    end else if (fire) begin
      raw_open_r <= raw_open_nxt;
      agree_r    <= agree_nxt;
      door_r     <= door_nxt;
      cand_r     <= cand_nxt;
      lab_r      <= lab_nxt;
      run_r      <= run_nxt;
      time_r     <= time_nxt;
      blink_r    <= blink_nxt;
      dur_r      <= dur_nxt;
      ovr_r      <= ovr_nxt;
      prompt_r   <= prompt_nxt;
    end
  end

endmodule

@@ rtl/door_debounce_countdown_top.sv @@
// ---------------------------------------------------------------------------
// door_debounce_countdown_top
// Door distance debounce with lab-state countdown, override and LED drives.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake          | carries
//  in_      | input     | in_tvalid/tready   | reading, tick or switch word
//  out_     | output    | out_tvalid/tready  | state, LED and change word
//  cfg_     | input     | cfg_valid/ready    | register index and data
//
// One word is accepted per cycle while in_tready is high; its result word is
// held first in the input register and then in the result register around
// the state logic before it is presented.
// rst_n is synchronous; it clears the state and loads the register defaults.
// A stalled output holds its word; the input register keeps filling until
// both registers are full, then in_tready drops. cfg_ready is always high.
// ---------------------------------------------------------------------------
`include "door_debounce_countdown_top_defines.svh"

module door_debounce_countdown_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [15:0] distance, [23:16] duration_s, [24] override_switch,
  // [25] prompt_switch, [31:26] zero
  input  logic [31:0]                   in_tdata,
  // [1:0] kind
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] lab_open, [1] door_open, [2] counting, [20:3] remaining_ms,
  // [21] led_green, [22] led_red, [23] led_white, [24] led_yellow,
  // [25] lab_changed, [26] special_prompt, [31:27] zero
  output logic [31:0]                   out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbc_pkg::DIST_W-1:0]    cfg_data
);
  import dbc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  result_t res_core;
  result_t res_r;
  logic    in_valid_r;
  logic    out_valid_r;
  logic    advance;
  logic    fire;
  logic    in_acc;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  dbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dbc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (fire),
    .item   (item_r),
    .result (res_core)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.kind            <= in_tuser;
      item_r.distance        <= in_tdata[15:0];
      item_r.duration_s      <= in_tdata[23:16];
      item_r.override_switch <= in_tdata[24];
      item_r.prompt_switch   <= in_tdata[25];
    end
    if (fire) begin
      res_r <= res_core;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0,
                       res_r.special_prompt,
                       res_r.lab_changed,
                       res_r.led_yellow,
                       res_r.led_white,
                       res_r.led_red,
                       res_r.led_green,
                       res_r.remaining_ms,
                       res_r.counting,
                       res_r.door_open,
                       res_r.lab_open};

  `DBC_ASSERT_NOW(a_commit_ends_count, out_valid_r && res_r.lab_changed, !res_r.counting && (res_r.remaining_ms == '0), "lab commit with countdown still live")
  `DBC_ASSERT_NOW(a_blink_needs_count, out_valid_r && res_r.led_white, res_r.counting, "white LED lit without a countdown")
  `DBC_ASSERT_NEXT(a_stalled_item_kept, in_valid_r && !advance, in_valid_r && $stable(item_r), "held input word lost under stall")

endmodule
